/* design/set_assoc_cache_fifo_lookup_macros.svh */
// assertion macros for the set-associative cache lookup
// used by set_assoc_cache_fifo_lookup.sv; expects clk and rst in scope
`ifndef SET_ASSOC_CACHE_FIFO_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_LOOKUP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SACF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SACF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sacf_pkg.sv */
// shared types and constants for the set-associative cache lookup
// no dependencies; imported by set_assoc_cache_fifo_lookup
package sacf_pkg;

  localparam int ADDR_W      = 32;
  localparam int BLK_W       = 32;
  localparam int OFFS_W      = 5;
  localparam int WLOG_W      = 3;
  localparam int CNT_W       = 32;
  localparam int IDX_OUT_W   = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [OFFS_W-1:0] OFFS_RESET = OFFS_W'(10);
  localparam logic [WLOG_W-1:0] WLOG_RESET = WLOG_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_WAYS_LOG2   = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_EVICT
  } state_t;

  // saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* design/set_assoc_cache_fifo_lookup.sv */
// set-associative cache lookup with fifo replacement, single module
// depends on sacf_pkg and set_assoc_cache_fifo_lookup_macros.svh
//
// Usage:
//   An access transaction is taken when start is high and busy is low; the
//   address is dropped by offset_bits to a block number whose low bits pick
//   a set. The ways of the set are read from the tag memory one per cycle
//   and compared; then the line is reported, filled or replaced (fifo order
//   through a per-set pointer).
//   The result shows for one cycle with done high; the receiver cannot stall
//   it. The scan reads ways entries (ways = 1 << ways_log2, clamped to
//   LINES; two ways by default), then a resolve state follows, and on a
//   replacement an evict state as well. busy stays high for all but the done
//   cycle, so no new transaction is taken until the current one is through;
//   the scan is bound by the single tag memory read port.
//   Configuration writes (cfg_valid, cfg_ready always high) go to the
//   register named by cfg_index and are meant for idle periods.
//   After reset a clearing pass over all LINES entries wipes the valid bits and
//   set pointers, with busy high. Counters reset to zero and saturate.
//   LINES is a power of two.
module set_assoc_cache_fifo_lookup
  import sacf_pkg::*;
#(
  parameter int LINES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     address,
  output logic                  done,
  output logic                  hit,
  output logic [IDX_OUT_W-1:0]  line_index,
  output logic                  evicted_valid,
  output logic [BLK_W-1:0]      evicted_block,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);

  // configuration registers
  logic [OFFS_W-1:0] offset_bits;
  logic [WLOG_W-1:0] ways_log2;

  // sequencer and per-transaction registers
  state_t            state, state_next;
  logic [LINE_W-1:0] clr_cnt;
  logic [BLK_W-1:0]  blk;
  logic [LINE_W-1:0] set_r;
  logic [LINE_W-1:0] base_r;
  logic [WLOG_W-1:0] w_r;
  logic [LINE_W:0]   issue_cnt;
  logic              cmp_vld;
  logic [LINE_W-1:0] cmp_way;
  logic              hit_found;
  logic [LINE_W-1:0] hit_line;
  logic              inv_found;
  logic [LINE_W-1:0] inv_line;
  logic [CNT_W-1:0]  hit_counter;
  logic [CNT_W-1:0]  miss_counter;

  // memories: tag word is {valid, block}, pointer per set
  logic [BLK_W:0]    tag_mem [LINES];
  logic [LINE_W-1:0] ptr_mem [LINES];
  logic [BLK_W:0]    tag_rdata;
  logic [LINE_W-1:0] ptr_rdata;

  logic              tag_we;
  logic [LINE_W-1:0] tag_waddr;
  logic [BLK_W:0]    tag_wdata;
  logic [LINE_W-1:0] tag_raddr;
  logic              ptr_we;
  logic [LINE_W-1:0] ptr_wdata;

  // geometry of the incoming transaction
  logic [WLOG_W-1:0] w_eff;
  logic [BLK_W-1:0]  blk_in;
  logic [LINE_W-1:0] set_in;
  logic [LINE_W:0]   ways;
  logic [LINE_W-1:0] ways_mask;
  logic [LINE_W-1:0] cmp_line;
  logic              cmp_match;
  logic              cmp_free;
  logic [LINE_W-1:0] ptr_cur;
  logic [LINE_W-1:0] evict_line;
  logic              accept;
  logic [LINE_W+IDX_OUT_W-1:0] line_ext;
  logic [LINE_W-1:0] res_line;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign w_eff  = (int'(ways_log2) > LINE_W) ? WLOG_W'(LINE_W) : ways_log2;
  assign blk_in = address >> offset_bits;
  assign set_in = blk_in[LINE_W-1:0] & (LINE_LAST >> w_eff);

  assign ways      = (LINE_W+1)'(1) << w_r;
  assign ways_mask = ~({LINE_W{1'b1}} << w_r);
  assign cmp_line  = base_r | cmp_way;
  assign cmp_match = tag_rdata[BLK_W] && (tag_rdata[BLK_W-1:0] == blk);
  assign cmp_free  = !tag_rdata[BLK_W];
  assign ptr_cur   = ptr_rdata & ways_mask;
  assign evict_line = base_r | ptr_cur;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFS_RESET;
      ways_log2   <= WLOG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_BITS: offset_bits <= cfg_data[OFFS_W-1:0];
        CFG_WAYS_LOG2:   ways_log2   <= cfg_data[WLOG_W-1:0];
        default:         ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_cnt == LINE_LAST) state_next = ST_IDLE;
      ST_IDLE:    if (start) state_next = ST_SCAN;
      ST_SCAN:    if (cmp_vld && (cmp_way == ways_mask)) state_next = ST_RESOLVE;
      ST_RESOLVE: begin
        if (hit_found || inv_found) state_next = ST_IDLE;
        else state_next = ST_EVICT;
      end
      ST_EVICT:   state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = clr_cnt;
    tag_wdata = '0;
    tag_raddr = base_r;
    ptr_we    = 1'b0;
    ptr_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        tag_we = 1'b1;
        ptr_we = 1'b1;
      end
      ST_SCAN: begin
        tag_raddr = base_r | issue_cnt[LINE_W-1:0];
      end
      ST_RESOLVE: begin
        tag_raddr = evict_line;
        if (!hit_found && inv_found) begin
          tag_we    = 1'b1;
          tag_waddr = inv_line;
          tag_wdata = {1'b1, blk};
        end
      end
      ST_EVICT: begin
        tag_we    = 1'b1;
        tag_waddr = evict_line;
        tag_wdata = {1'b1, blk};
        ptr_we    = 1'b1;
        ptr_wdata = (ptr_cur + LINE_W'(1)) & ways_mask;
      end
      default: ;
    endcase
  end

  // tag memory, registered read
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    tag_rdata <= tag_mem[tag_raddr];
  end

  // set pointer memory, written at the sweep address during clearing and at the set on a replacement
  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[(state == ST_CLEAR) ? clr_cnt : set_r] <= ptr_wdata;
    ptr_rdata <= ptr_mem[set_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      done         <= 1'b0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + LINE_W'(1);
      if (state == ST_RESOLVE) begin
        if (hit_found) begin
          hit_counter <= sat_inc(hit_counter);
        end else begin
          miss_counter <= sat_inc(miss_counter);
        end
        if (hit_found || inv_found) done <= 1'b1;
      end
      if (state == ST_EVICT) done <= 1'b1;
    end
  end

  // way scan: issue one read a cycle, compare the one issued before
  always_ff @(posedge clk) begin
    if (accept) begin
      blk       <= blk_in;
      set_r     <= set_in;
      base_r    <= set_in << w_eff;
      w_r       <= w_eff;
      issue_cnt <= '0;
      cmp_vld   <= 1'b0;
      hit_found <= 1'b0;
      inv_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (issue_cnt != ways) begin
        issue_cnt <= issue_cnt + (LINE_W+1)'(1);
        cmp_vld   <= 1'b1;
        cmp_way   <= issue_cnt[LINE_W-1:0];
      end else begin
        cmp_vld <= 1'b0;
      end
      if (cmp_vld) begin
        if (!hit_found && cmp_match) begin
          hit_found <= 1'b1;
          hit_line  <= cmp_line;
        end
        if (!inv_found && cmp_free) begin
          inv_found <= 1'b1;
          inv_line  <= cmp_line;
        end
      end
    end
  end

  // result registers
  always_comb begin
    if (state == ST_EVICT) res_line = evict_line;
    else if (hit_found) res_line = hit_line;
    else res_line = inv_line;
  end
  assign line_ext = {{IDX_OUT_W{1'b0}}, res_line};

  always_ff @(posedge clk) begin
    if ((state == ST_RESOLVE) || (state == ST_EVICT)) begin
      hit           <= (state == ST_RESOLVE) && hit_found;
      line_index    <= line_ext[IDX_OUT_W-1:0];
      evicted_valid <= (state == ST_EVICT);
      evicted_block <= (state == ST_EVICT) ? tag_rdata[BLK_W-1:0] : '0;
    end
  end

  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;

  // checks
  `include "set_assoc_cache_fifo_lookup_macros.svh"

  `SACF_ASSERT_NOW(a_hit_no_evict, done && hit, !evicted_valid && (evicted_block == '0),
    "hit reported together with an eviction")
  `SACF_ASSERT_NEXT(a_accept_scans, start && !busy, state == ST_SCAN,
    "accepted transaction did not start the way scan")
  `SACF_ASSERT_NOW(a_issue_bound, state == ST_SCAN, issue_cnt <= ways,
    "way scan ran past the ways of the set")
  `SACF_ASSERT_NEXT(a_evict_done, state == ST_EVICT, done && evicted_valid,
    "replacement finished without a result")

endmodule
